@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked during reset
`define LSSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked assertion, live during reset
`define LSSC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ src/lssc_pkg.sv @@
// Shared types, codes and constants of the line sensor steering controller
`timescale 1ns / 1ps
`default_nettype none
package lssc_pkg;

  localparam int MAX_SPEED_DEF     = 1000;
  localparam int WHEEL_SPACING_DEF = 150;

  localparam int TURN_W = 13;
  localparam int SPD_W  = 11;
  localparam int YAW_W  = 15;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_RIGHT_ANGLE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BIG_TURN    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MID_TURN    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SMALL_TURN  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CRUISE      = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SLOWDOWN    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_STRAIGHT    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_HOLD        = 3'd7;

  localparam logic [3:0] PAT_WHITE    = 4'h0;
  localparam logic [3:0] PAT_FAR_R    = 4'h1;
  localparam logic [3:0] PAT_RIGHT_2  = 4'h3;
  localparam logic [3:0] PAT_BIG_L    = 4'h7;
  localparam logic [3:0] PAT_FAR_L    = 4'h8;
  localparam logic [3:0] PAT_STRAIGHT = 4'h9;
  localparam logic [3:0] PAT_SMALL_L  = 4'hB;
  localparam logic [3:0] PAT_LEFT_2   = 4'hC;
  localparam logic [3:0] PAT_SMALL_R  = 4'hD;
  localparam logic [3:0] PAT_BIG_R    = 4'hE;
  localparam logic [3:0] PAT_BLACK    = 4'hF;

  typedef struct packed {
    logic [11:0] right_angle_turn;
    logic [11:0] big_turn;
    logic [11:0] mid_turn;
    logic [11:0] small_turn;
    logic [9:0]  cruise_speed;
    logic [11:0] slowdown_limit;
    logic [15:0] straight_ticks;
    logic [15:0] hold_ticks;
  } cfg_t;

  function automatic logic signed [TURN_W-1:0] pos_turn(input logic [11:0] v);
    return $signed({1'b0, v});
  endfunction

  function automatic logic signed [TURN_W-1:0] neg_turn(input logic [11:0] v);
    return -$signed({1'b0, v});
  endfunction

endpackage
`default_nettype wire

@@ src/lssc_front.sv @@
// Front end: tick counter, pattern hold and turn classification
`timescale 1ns / 1ps
`default_nettype none
module lssc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lssc_pkg::cfg_t                     cfg,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [3:0]                         in_sensor_pattern,
  input  logic                               q_full,
  output logic                               q_push,
  output logic signed [lssc_pkg::TURN_W-1:0] q_turn
);
  import lssc_pkg::*;

  logic [15:0]              cnt_r, cnt_nxt;
  logic [3:0]               saved_r, saved_nxt;
  logic [3:0]               last_r, last_nxt;
  logic signed [TURN_W-1:0] turn_r, turn_nxt;
  logic [3:0]               p, pe;
  logic                     right_angle;

  assign in_full = q_full;
  assign q_push  = in_push & ~q_full;
  assign q_turn  = turn_nxt;
  assign p       = in_sensor_pattern;
  assign right_angle = (p == PAT_FAR_R) || (p == PAT_FAR_L) ||
                       (p == PAT_RIGHT_2) || (p == PAT_LEFT_2);

  always_comb begin
    cnt_nxt   = cnt_r;
    saved_nxt = saved_r;
    pe        = p;
    if (right_angle && cnt_r == 16'd0) begin
      saved_nxt = p;
      cnt_nxt   = 16'd1;
    end
    if (cnt_nxt != 16'd0) begin
      if (cnt_nxt < cfg.straight_ticks) begin
        pe = PAT_STRAIGHT;
      end else if (cnt_nxt < cfg.hold_ticks && p != PAT_BIG_L && p != PAT_BIG_R) begin
        pe = saved_nxt;
      end else begin
        cnt_nxt   = 16'd0;
        saved_nxt = 4'd0;
      end
      if (cnt_nxt != 16'd0) begin
        cnt_nxt = cnt_nxt + 16'd1;
      end
    end
    turn_nxt = turn_r;
    case (pe)
      PAT_FAR_R, PAT_RIGHT_2: turn_nxt = pos_turn(cfg.right_angle_turn);
      PAT_FAR_L, PAT_LEFT_2:  turn_nxt = neg_turn(cfg.right_angle_turn);
      PAT_BIG_L:              turn_nxt = pos_turn(cfg.big_turn);
      PAT_BIG_R:              turn_nxt = neg_turn(cfg.big_turn);
      PAT_SMALL_L:            turn_nxt = pos_turn(cfg.small_turn);
      PAT_SMALL_R:            turn_nxt = neg_turn(cfg.small_turn);
      PAT_BLACK: begin
        if (last_r == PAT_SMALL_L) turn_nxt = pos_turn(cfg.mid_turn);
        else if (last_r == PAT_SMALL_R) turn_nxt = neg_turn(cfg.mid_turn);
        else if (last_r == PAT_BIG_L) turn_nxt = pos_turn(cfg.big_turn);
        else if (last_r == PAT_BIG_R) turn_nxt = neg_turn(cfg.big_turn);
      end
      default: turn_nxt = '0;
    endcase
    last_nxt = (pe != PAT_BLACK) ? pe : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      saved_r <= '0;
      last_r  <= '0;
      turn_r  <= '0;
    end else if (q_push) begin
      cnt_r   <= cnt_nxt;
      saved_r <= saved_nxt;
      last_r  <= last_nxt;
      turn_r  <= turn_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/lssc_fifo.sv @@
// Two-entry queue of turn values between front and back end
`timescale 1ns / 1ps
`default_nettype none
module lssc_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  logic signed [lssc_pkg::TURN_W-1:0] wdata,
  output logic                               full,
  input  logic                               pop,
  output logic                               empty,
  output logic signed [lssc_pkg::TURN_W-1:0] rdata
);
  import lssc_pkg::*;

  logic signed [TURN_W-1:0] mem_r [2];
  logic                     wptr_r, rptr_r;
  logic [1:0]               count_r;
  logic                     do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop)  rptr_r <= ~rptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

@@ src/lssc_back.sv @@
// Back end: speed scaling, wheel clamp, forward speed and yaw rate
`timescale 1ns / 1ps
`default_nettype none
module lssc_back #(
  parameter int MAX_SPEED     = lssc_pkg::MAX_SPEED_DEF,
  parameter int WHEEL_SPACING = lssc_pkg::WHEEL_SPACING_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lssc_pkg::cfg_t                     cfg,
  input  logic                               q_empty,
  input  logic signed [lssc_pkg::TURN_W-1:0] q_turn,
  output logic                               q_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [lssc_pkg::TURN_W-1:0] out_turn_differential,
  output logic signed [lssc_pkg::SPD_W-1:0]  out_left_wheel_speed,
  output logic signed [lssc_pkg::SPD_W-1:0]  out_right_wheel_speed,
  output logic signed [lssc_pkg::SPD_W-1:0]  out_forward_speed,
  output logic signed [lssc_pkg::YAW_W-1:0]  out_yaw_rate
);
  import lssc_pkg::*;

  localparam int SPD_HI = (MAX_SPEED > 1023) ? 1023 : MAX_SPEED;
  localparam logic signed [14:0] HI_P = 15'(SPD_HI);
  localparam logic signed [14:0] HI_N = -15'(SPD_HI);
  localparam int NUM_W = 22;
  localparam logic [4:0] LAST_STEP = 5'(NUM_W - 1);

  // Reciprocal of the wheel spacing, exact for dividends below 2**YAW_N
  localparam int     YAW_N  = 21;
  localparam int     YAW_MW = 22;
  localparam int     PROD_W = YAW_N + YAW_MW;
  localparam int     YAW_SH = YAW_N + $clog2(WHEEL_SPACING);
  localparam longint YAW_M  = ((longint'(1) << YAW_SH) + longint'(WHEEL_SPACING) - 1)
                              / longint'(WHEEL_SPACING);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_WHEEL = 3'd3;
  localparam logic [2:0] S_YAW   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic signed [TURN_W-1:0] turn_r;
  logic [NUM_W-1:0]         num_r;
  logic [11:0]              rem_r, den_r;
  logic [4:0]               cnt_r;
  logic signed [SPD_W-1:0]  left_r, right_r;
  logic                     neg_r;
  logic                     valid_r;

  logic [12:0]              rem_sh;
  logic                     ge;
  logic [11:0]              mag;
  logic signed [14:0]       lw, rw, lc, rc;
  logic signed [11:0]       diff, wsum, fwd_tmp;
  logic [10:0]              dmag;
  logic signed [YAW_W-1:0]  yaw;
  logic                     load;
  logic [PROD_W-1:0]        yprod;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign mag    = turn_r[TURN_W-1] ? 12'(-turn_r) : turn_r[11:0];
  assign lw     = 15'($signed({1'b0, num_r[9:0]})) - 15'(turn_r);
  assign rw     = 15'($signed({1'b0, num_r[9:0]})) + 15'(turn_r);
  assign lc     = (lw > HI_P) ? HI_P : ((lw < HI_N) ? HI_N : lw);
  assign rc     = (rw > HI_P) ? HI_P : ((rw < HI_N) ? HI_N : rw);
  assign diff   = 12'(right_r) - 12'(left_r);
  assign dmag   = diff[11] ? 11'(-diff) : diff[10:0];
  assign wsum   = 12'(left_r) + 12'(right_r);
  assign fwd_tmp = (wsum + {11'd0, wsum[11]}) >>> 1;
  assign yprod  = PROD_W'(num_r[YAW_N-1:0]) * PROD_W'(YAW_M);
  assign load   = (state_r == S_OUT) && (!valid_r || out_pop);
  assign q_pop  = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !valid_r;

  always_comb begin
    if (neg_r) yaw = (num_r > NUM_W'(16384)) ? -15'sd16384 : -$signed(15'(num_r));
    else       yaw = (num_r > NUM_W'(16383)) ? 15'sd16383 : $signed(15'(num_r));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIV1;
      S_DIV1:  if (cnt_r == LAST_STEP) state_nxt = S_WHEEL;
      S_WHEEL: state_nxt = S_YAW;
      S_YAW:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_OUT;
      S_OUT:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) valid_r <= 1'b1;
      else if (out_pop) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: turn_r <= q_turn;
      S_MUL: begin
        if (mag < cfg.slowdown_limit) begin
          num_r <= NUM_W'(cfg.cruise_speed) * NUM_W'(cfg.slowdown_limit - mag);
          den_r <= cfg.slowdown_limit;
        end else begin
          num_r <= '0;
          den_r <= 12'd1;
        end
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV1: begin
        rem_r <= ge ? 12'(rem_sh - {1'b0, den_r}) : rem_sh[11:0];
        num_r <= {num_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      S_WHEEL: begin
        left_r  <= lc[SPD_W-1:0];
        right_r <= rc[SPD_W-1:0];
      end
      S_YAW: begin
        num_r <= NUM_W'(dmag) * NUM_W'(1000);
        neg_r <= diff[11];
      end
      S_SCALE: num_r <= NUM_W'(yprod >> YAW_SH);
      default: ;
    endcase
    if (load) begin
      out_turn_differential <= turn_r;
      out_left_wheel_speed  <= left_r;
      out_right_wheel_speed <= right_r;
      out_forward_speed     <= fwd_tmp[SPD_W-1:0];
      out_yaw_rate          <= yaw;
    end
  end
endmodule
`default_nettype wire

@@ src/line_sensor_steering_controller_top.sv @@
// Top level of the line sensor steering controller
`timescale 1ns / 1ps
`default_nettype none
// Takes one 4-bit sensor pattern per control tick and returns one result per
// request: turn differential, clamped wheel speeds, forward speed and yaw rate.
// The front end classifies a request in the cycle it is pushed and queues the
// turn (two entries); the back end takes one turn at a time, scales the speed
// with a 22-step restoring divider and divides the yaw rate by the wheel
// spacing with a single reciprocal multiply. A result that is not popped holds
// the back end in its output state. The user writes registers through the cfg_
// port while the block is idle (not enforced); they reset to their defaults.
module line_sensor_steering_controller_top #(
  parameter int MAX_SPEED     = lssc_pkg::MAX_SPEED_DEF,
  parameter int WHEEL_SPACING = lssc_pkg::WHEEL_SPACING_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lssc_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [lssc_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [3:0]                         in_sensor_pattern,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [lssc_pkg::TURN_W-1:0] out_turn_differential,
  output logic signed [lssc_pkg::SPD_W-1:0]  out_left_wheel_speed,
  output logic signed [lssc_pkg::SPD_W-1:0]  out_right_wheel_speed,
  output logic signed [lssc_pkg::SPD_W-1:0]  out_forward_speed,
  output logic signed [lssc_pkg::YAW_W-1:0]  out_yaw_rate
);
  import lssc_pkg::*;

  cfg_t                     cfg_r;
  logic                     q_push, q_full, q_pop, q_empty;
  logic signed [TURN_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{right_angle_turn: 12'd0, big_turn: 12'd0, mid_turn: 12'd0,
                 small_turn: 12'd0, cruise_speed: 10'd150, slowdown_limit: 12'd1,
                 straight_ticks: 16'd0, hold_ticks: 16'd0};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RIGHT_ANGLE: cfg_r.right_angle_turn <= cfg_wdata[11:0];
        REG_BIG_TURN:    cfg_r.big_turn         <= cfg_wdata[11:0];
        REG_MID_TURN:    cfg_r.mid_turn         <= cfg_wdata[11:0];
        REG_SMALL_TURN:  cfg_r.small_turn       <= cfg_wdata[11:0];
        REG_CRUISE:      cfg_r.cruise_speed     <= cfg_wdata[9:0];
        REG_SLOWDOWN:    cfg_r.slowdown_limit   <= cfg_wdata[11:0];
        REG_STRAIGHT:    cfg_r.straight_ticks   <= cfg_wdata;
        REG_HOLD:        cfg_r.hold_ticks       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lssc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_push(in_push), .in_full(in_full), .in_sensor_pattern(in_sensor_pattern),
    .q_full(q_full), .q_push(q_push), .q_turn(q_wdata)
  );

  lssc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  lssc_back #(.MAX_SPEED(MAX_SPEED), .WHEEL_SPACING(WHEEL_SPACING)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_empty(q_empty), .q_turn(q_rdata), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_turn_differential(out_turn_differential),
    .out_left_wheel_speed(out_left_wheel_speed),
    .out_right_wheel_speed(out_right_wheel_speed),
    .out_forward_speed(out_forward_speed),
    .out_yaw_rate(out_yaw_rate)
  );
endmodule
`default_nettype wire

@@ src/lssc_checker.sv @@
// Port-level checker of the steering controller and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lssc_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               out_empty,
  input wire                               out_pop,
  input wire signed [lssc_pkg::TURN_W-1:0] out_turn_differential,
  input wire signed [lssc_pkg::SPD_W-1:0]  out_left_wheel_speed,
  input wire signed [lssc_pkg::SPD_W-1:0]  out_right_wheel_speed,
  input wire signed [lssc_pkg::YAW_W-1:0]  out_yaw_rate
);
  `LSSC_ASSERT_RST(a_empty_after_reset, clk, !rst_n |=> out_empty)
  `LSSC_ASSERT(a_result_holds, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_turn_differential)))
  `LSSC_ASSERT(a_yaw_sign, clk, rst_n, !out_empty |-> ((out_right_wheel_speed < out_left_wheel_speed) == (out_yaw_rate < 0)))
  `LSSC_ASSERT(a_wheel_range, clk, rst_n, !out_empty |-> (out_left_wheel_speed >= -1023 && out_right_wheel_speed >= -1023 && out_turn_differential != -4096))
endmodule

bind line_sensor_steering_controller_top lssc_checker u_lssc_checker (.*);
`default_nettype wire

@@ sim/lssc_checker.sv @@
// Checker for the line sensor steering controller: predicts each result and compares
`timescale 1ns / 1ps
`default_nettype none
module lssc_scoreboard (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lssc_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [lssc_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                               in_push,
  input  logic                               in_full,
  input  logic [3:0]                         in_sensor_pattern,
  input  logic                               out_empty,
  input  logic                               out_pop,
  input  logic signed [lssc_pkg::TURN_W-1:0] out_turn_differential,
  input  logic signed [lssc_pkg::SPD_W-1:0]  out_left_wheel_speed,
  input  logic signed [lssc_pkg::SPD_W-1:0]  out_right_wheel_speed,
  input  logic signed [lssc_pkg::SPD_W-1:0]  out_forward_speed,
  input  logic signed [lssc_pkg::YAW_W-1:0]  out_yaw_rate,
  output int                                 errors,
  output int                                 pending
);
  import lssc_pkg::*;

  typedef struct packed {
    logic signed [TURN_W-1:0] turn;
    logic signed [SPD_W-1:0]  left;
    logic signed [SPD_W-1:0]  right;
    logic signed [SPD_W-1:0]  fwd;
    logic signed [YAW_W-1:0]  yaw;
  } steer_t;

  cfg_t   regs;
  int     tick_count;
  logic [3:0] held_pat, prev_pat;
  int     turn_now;
  steer_t steer_q[$];

  function automatic int clip(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic steer_predict(input logic [3:0] raw);
    logic [3:0] p;
    int mag, base, l, r, hi;
    steer_t s;
    p = raw;
    if ((p == PAT_FAR_R || p == PAT_FAR_L || p == PAT_RIGHT_2 || p == PAT_LEFT_2)
        && tick_count == 0) begin
      held_pat = p;
      tick_count = 1;
    end
    if (tick_count > 0) begin
      if (tick_count < regs.straight_ticks) p = PAT_STRAIGHT;
      else if (tick_count < regs.hold_ticks && p != PAT_BIG_L && p != PAT_BIG_R)
        p = held_pat;
      else begin
        tick_count = 0;
        held_pat = '0;
      end
      if (tick_count > 0) tick_count = (tick_count + 1) & 16'hFFFF;
    end
    case (p)
      PAT_FAR_R, PAT_RIGHT_2: turn_now = regs.right_angle_turn;
      PAT_FAR_L, PAT_LEFT_2:  turn_now = -int'(regs.right_angle_turn);
      PAT_BIG_L:              turn_now = regs.big_turn;
      PAT_BIG_R:              turn_now = -int'(regs.big_turn);
      PAT_SMALL_L:            turn_now = regs.small_turn;
      PAT_SMALL_R:            turn_now = -int'(regs.small_turn);
      PAT_BLACK: begin
        if (prev_pat == PAT_SMALL_L) turn_now = regs.mid_turn;
        else if (prev_pat == PAT_SMALL_R) turn_now = -int'(regs.mid_turn);
        else if (prev_pat == PAT_BIG_L) turn_now = regs.big_turn;
        else if (prev_pat == PAT_BIG_R) turn_now = -int'(regs.big_turn);
      end
      default: turn_now = 0;
    endcase
    if (p != PAT_BLACK) prev_pat = p;
    mag = turn_now < 0 ? -turn_now : turn_now;
    if (mag < int'(regs.slowdown_limit))
      base = (int'(regs.cruise_speed) * (int'(regs.slowdown_limit) - mag))
             / int'(regs.slowdown_limit);
    else base = 0;
    hi = MAX_SPEED_DEF > 1023 ? 1023 : MAX_SPEED_DEF;
    l = clip(base - turn_now, -hi, hi);
    r = clip(base + turn_now, -hi, hi);
    s.turn  = TURN_W'(turn_now);
    s.left  = SPD_W'(l);
    s.right = SPD_W'(r);
    s.fwd   = SPD_W'((l + r) / 2);
    s.yaw   = YAW_W'(clip(((r - l) * 1000) / WHEEL_SPACING_DEF, -16384, 16383));
    steer_q.push_back(s);
  endtask

  always @(posedge clk) begin
    steer_t e, a;
    if (!rst_n) begin
      regs <= '{right_angle_turn: 12'd0, big_turn: 12'd0, mid_turn: 12'd0,
                small_turn: 12'd0, cruise_speed: 10'd150, slowdown_limit: 12'd1,
                straight_ticks: 16'd0, hold_ticks: 16'd0};
      tick_count = 0;
      held_pat = '0;
      prev_pat = '0;
      turn_now = 0;
      errors <= 0;
      steer_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_RIGHT_ANGLE: regs.right_angle_turn <= cfg_wdata[11:0];
          REG_BIG_TURN:    regs.big_turn <= cfg_wdata[11:0];
          REG_MID_TURN:    regs.mid_turn <= cfg_wdata[11:0];
          REG_SMALL_TURN:  regs.small_turn <= cfg_wdata[11:0];
          REG_CRUISE:      regs.cruise_speed <= cfg_wdata[9:0];
          REG_SLOWDOWN:    regs.slowdown_limit <= cfg_wdata[11:0];
          REG_STRAIGHT:    regs.straight_ticks <= cfg_wdata;
          REG_HOLD:        regs.hold_ticks <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full) steer_predict(in_sensor_pattern);
      if (out_pop && !out_empty) begin
        a = {out_turn_differential, out_left_wheel_speed, out_right_wheel_speed,
             out_forward_speed, out_yaw_rate};
        if (steer_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", a);
          errors <= errors + 1;
        end else begin
          e = steer_q.pop_front();
          if (e !== a) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", e, a);
            errors <= errors + 1;
          end
        end
      end
      pending <= steer_q.size();
    end
  end
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench top: stimulus, configuration phases and verdict for the steering controller
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import lssc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_RIGHT_ANGLE;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_push = 1'b0;
  logic [3:0] in_sensor_pattern = '0;
  logic out_pop = 1'b0;
  logic in_full, out_empty;
  logic signed [TURN_W-1:0] out_turn_differential;
  logic signed [SPD_W-1:0] out_left_wheel_speed, out_right_wheel_speed, out_forward_speed;
  logic signed [YAW_W-1:0] out_yaw_rate;
  int errors, pending;
  int send_idle, pop_stall;

  always #5 clk = ~clk;

  line_sensor_steering_controller_top u_dut (.*);
  lssc_scoreboard u_chk (.*);

  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= pop_stall);
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pattern(input logic [3:0] pat);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_sensor_pattern <= pat;
    while (in_full) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_all(input int ra, input int bt, input int mt, input int st,
                         input int cs, input int sl, input int sk, input int hk);
    write_reg(REG_RIGHT_ANGLE, CFG_DW'(ra));
    write_reg(REG_BIG_TURN, CFG_DW'(bt));
    write_reg(REG_MID_TURN, CFG_DW'(mt));
    write_reg(REG_SMALL_TURN, CFG_DW'(st));
    write_reg(REG_CRUISE, CFG_DW'(cs));
    write_reg(REG_SLOWDOWN, CFG_DW'(sl));
    write_reg(REG_STRAIGHT, CFG_DW'(sk));
    write_reg(REG_HOLD, CFG_DW'(hk));
  endtask

  function automatic logic [3:0] random_pattern;
    int r;
    r = $urandom_range(9);
    case (r)
      0: return PAT_FAR_R;
      1: return PAT_LEFT_2;
      2: return PAT_BIG_L;
      3: return PAT_BIG_R;
      4: return PAT_SMALL_L;
      5: return PAT_SMALL_R;
      6: return PAT_BLACK;
      7: return PAT_STRAIGHT;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  initial begin
    int k;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 0;
    pop_stall = 0;
    for (k = 0; k < 16; k++) send_pattern(4'(k));
    drain_results();
    set_all(300, 500, 200, 100, 400, 1000, 2, 5);
    send_pattern(PAT_SMALL_L); send_pattern(PAT_BLACK);
    send_pattern(PAT_SMALL_R); send_pattern(PAT_BLACK);
    send_pattern(PAT_FAR_L);   send_pattern(PAT_WHITE); send_pattern(PAT_WHITE);
    send_pattern(PAT_WHITE);   send_pattern(PAT_BIG_R); send_pattern(PAT_BLACK);
    drain_results();
    set_all(4095, 4095, 4095, 4095, 1000, 0, 0, 0);
    send_pattern(PAT_RIGHT_2); send_pattern(PAT_LEFT_2); send_pattern(PAT_BIG_L);
    send_pattern(PAT_BLACK);
    drain_results();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  pop_stall = 0;  end
        1: begin send_idle = 82; pop_stall = 0;  end
        2: begin send_idle = 0;  pop_stall = 82; end
        3: begin send_idle = 26; pop_stall = 26; end
        default: begin send_idle = 0; pop_stall = 0; end
      endcase
      if (ph == 4) set_all(4095, 4095, 4095, 4095, 1023, 4095, 65535, 65535);
      else set_all($urandom_range(600), $urandom_range(800), $urandom_range(600),
                   $urandom_range(300), $urandom_range(1000), $urandom_range(1200),
                   $urandom_range(6), $urandom_range(12));
      for (k = 0; k < 105; k++) send_pattern(random_pattern());
      drain_results();
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
